@@ rtl/lphs_pkg.sv @@
// Shared types and constants for the linear-probing hash set.
// Used by lphs_ctrl, lphs_dp and linear_probe_hash_set_top; no dependencies.
`default_nettype none

package lphs_pkg;

   localparam int NUM_SLOTS_DEF  = 16;
   localparam int KEY_WIDTH_DEF  = 32;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 4;
   localparam int DIGIT_W    = 4;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd5;

   typedef struct packed {
      logic accept;
      logic home;
      logic probe;
      logic clear;
      logic load_out;
   } lphs_cmd_type;

   typedef struct packed {
      logic key_zero;
      logic home_done;
      logic hit;
      logic clear_last;
      logic out_busy;
   } lphs_sts_type;

endpackage

`default_nettype wire

@@ rtl/linear_probe_hash_set_top.sv @@
// Top level of the linear-probing hash set of nonzero keys.
// The probe compares 1..NUM_SLOTS slots from the home slot, one memory read per probe cycle;
// a request is held longer while an earlier result is still pending and rsp_tready is low.
// When NUM_SLOTS is not a power of two, the home slot comes from a digit-serial reduction of the key.
// A zero key skips the home slot and the probe and returns status INVALID.
// After reset a clearing pass empties all NUM_SLOTS slots of the memory; req_tready stays low.
`default_nettype none

module linear_probe_hash_set_top #(
   parameter int NUM_SLOTS  = lphs_pkg::NUM_SLOTS_DEF,
   parameter int KEY_WIDTH  = lphs_pkg::KEY_WIDTH_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [lphs_pkg::REQ_DATA_W-1:0]  req_tdata,   // key[31:0]
   input  wire                              req_tuser,   // mode (0 insert, 1 search)
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [lphs_pkg::RSP_DATA_W-1:0]  rsp_tdata    // status[2:0], slot[6:3], bit 7 always 0
);
   import lphs_pkg::*;

   lphs_cmd_type cmd;
   lphs_sts_type sts;

   lphs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lphs_dp #(
      .NUM_SLOTS  (NUM_SLOTS),
      .KEY_WIDTH  (KEY_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ap_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_tvalid && !rsp_tready))
      else $error("pending result overwritten");

   ap_probe_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.probe && sts.hit |=> !cmd.probe)
      else $error("probe continued after a hit");

   ap_one_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in progress");

endmodule

`default_nettype wire

@@ rtl/lphs_ctrl.sv @@
// Controller state machine of the hash set: clearing pass, home slot, probe, result.
// Depends on lphs_pkg; drives the datapath lphs_dp through command and status structs.
`default_nettype none

module lphs_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  lphs_pkg::lphs_sts_type sts,
   output lphs_pkg::lphs_cmd_type cmd
);
   import lphs_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HOME  = 3'd2;
   localparam logic [2:0] S_PROBE = 3'd3;
   localparam logic [2:0] S_HOLD  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = sts.key_zero ? S_HOLD : S_HOME;
            end
         end
         S_HOME: begin
            cmd.home = 1'b1;
            if (sts.home_done) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            cmd.probe = 1'b1;
            if (sts.hit) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (!sts.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lphs_dp.sv @@
// Datapath of the hash set: key table memory, home slot reduction, probe compare, result register.
// Depends on lphs_pkg; commanded by lphs_ctrl.
`default_nettype none

module lphs_dp #(
   parameter int NUM_SLOTS  = lphs_pkg::NUM_SLOTS_DEF,
   parameter int KEY_WIDTH  = lphs_pkg::KEY_WIDTH_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  [lphs_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire                                  req_tuser,
   input  lphs_pkg::lphs_cmd_type               cmd,
   output lphs_pkg::lphs_sts_type               sts,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [lphs_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import lphs_pkg::*;

   localparam int IDX_W    = $clog2(NUM_SLOTS);
   localparam int KEY_BITS = (KEY_WIDTH < REQ_DATA_W) ? KEY_WIDTH : REQ_DATA_W;
   localparam int NUM_DIG  = (KEY_BITS + DIGIT_W - 1) / DIGIT_W;
   localparam int DIG_W    = $clog2(NUM_DIG);
   localparam int SHF_W    = NUM_DIG * DIGIT_W;
   localparam int RW       = IDX_W + DIGIT_W;
   localparam bit IS_POW2  = (NUM_SLOTS & (NUM_SLOTS - 1)) == 0;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
   localparam logic [DIG_W-1:0] LAST_DIG = DIG_W'(NUM_DIG - 1);
   localparam logic [RW-1:0]    TS_R     = RW'(NUM_SLOTS);

   logic [KEY_WIDTH-1:0] mem [NUM_SLOTS];

   logic                 mode_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;
   logic [SHF_W-1:0]     kshift_ff;
   logic [IDX_W-1:0]     rem_ff;
   logic [IDX_W-1:0]     rem_in;
   logic [DIG_W-1:0]     dig_ff;
   logic [RW-1:0]        red;
   logic [IDX_W-1:0]     home_idx;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [IDX_W-1:0]     rd_idx_inc;
   logic [IDX_W-1:0]     q_idx_ff;
   logic [KEY_WIDTH-1:0] q_ff;
   logic                 q_vld_ff;
   logic [IDX_W-1:0]     cnt_ff;
   logic                 hit_empty;
   logic                 hit_match;
   logic                 exhaust;
   logic                 ins_wr;
   logic [STATUS_W-1:0]  res_status_ff;
   logic [SLOT_W-1:0]    res_slot_ff;
   logic [STATUS_W-1:0]  res_status_in;
   logic [SLOT_W-1:0]    res_slot_in;
   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign key_in     = KEY_WIDTH'(req_tdata);
   assign rd_idx_inc = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;

   // Home slot: restoring reduction, one digit per cycle from the top; pow2 sizes use key bits.
   always_comb begin
      red = {rem_ff, kshift_ff[SHF_W-1 -: DIGIT_W]};
      for (int j = DIGIT_W - 1; j >= 0; j--) begin
         if (red >= (TS_R << j)) begin
            red = red - (TS_R << j);
         end
      end
      rem_in   = red[IDX_W-1:0];
      home_idx = IS_POW2 ? IDX_W'(key_ff) : rem_in;
   end

   assign hit_empty = q_vld_ff && (q_ff == '0);
   assign hit_match = q_vld_ff && (q_ff == key_ff);
   assign exhaust   = q_vld_ff && !hit_empty && !hit_match && (cnt_ff == LAST_IDX);
   assign ins_wr    = cmd.probe && hit_empty && (mode_ff == MODE_INSERT);

   always_comb begin
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      priority if (cmd.accept) begin
         res_status_in = ST_INVALID;
         res_slot_in   = '0;
      end else if (cmd.probe && hit_empty) begin
         res_status_in = (mode_ff == MODE_SEARCH) ? ST_ABSENT : ST_INSERTED;
         res_slot_in   = (mode_ff == MODE_SEARCH) ? '0 : SLOT_W'(q_idx_ff);
      end else if (cmd.probe && hit_match) begin
         res_status_in = (mode_ff == MODE_SEARCH) ? ST_FOUND : ST_PRESENT;
         res_slot_in   = SLOT_W'(q_idx_ff);
      end else if (cmd.probe && exhaust) begin
         res_status_in = (mode_ff == MODE_SEARCH) ? ST_ABSENT : ST_FULL;
         res_slot_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[rd_idx_ff] <= '0;
      end else if (ins_wr) begin
         mem[q_idx_ff] <= key_ff;
      end
      q_ff     <= mem[rd_idx_ff];
      q_idx_ff <= rd_idx_ff;
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      if (cmd.accept) begin
         mode_ff   <= req_tuser;
         key_ff    <= key_in;
         kshift_ff <= SHF_W'(req_tdata[KEY_BITS-1:0]);
         rem_ff    <= '0;
      end else if (cmd.home) begin
         kshift_ff <= kshift_ff << DIGIT_W;
         rem_ff    <= rem_in;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= RSP_DATA_W'({res_slot_ff, res_status_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         q_vld_ff     <= 1'b0;
         cnt_ff       <= '0;
         dig_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         q_vld_ff <= cmd.probe;
         if (cmd.accept) begin
            dig_ff <= '0;
         end else if (cmd.home) begin
            dig_ff <= dig_ff + 1'b1;
         end
         if (cmd.home) begin
            cnt_ff <= '0;
         end else if (cmd.probe && q_vld_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.home && sts.home_done) begin
            rd_idx_ff <= home_idx;
         end else if (cmd.probe || cmd.clear) begin
            rd_idx_ff <= rd_idx_inc;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.key_zero   = (key_in == '0);
   assign sts.home_done  = IS_POW2 ? 1'b1 : (dig_ff == LAST_DIG);
   assign sts.hit        = hit_empty || hit_match || exhaust;
   assign sts.clear_last = (rd_idx_ff == LAST_IDX);
   assign sts.out_busy   = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   ap_ins_on_empty: assert property (@(posedge clock) disable iff (reset)
      ins_wr |-> !cmd.clear && q_vld_ff)
      else $error("insert write without a compared empty slot");

   ap_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.probe && q_vld_ff && !sts.hit |=> cnt_ff != '0)
      else $error("probe count wrapped without ending the probe");

   ap_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_out))
      else $error("result appeared without a load");

endmodule

`default_nettype wire
